// ----- hw/rtl/tdpt_pkg.sv -----
`timescale 1ns / 1ps

package tdpt_pkg;

	// Width of the number under test
	localparam int unsigned NUM_BITS = 31;

	// Trial divisor width: covers sqrt(2^NUM_BITS) plus one step of headroom
	localparam int unsigned DIV_BITS = (NUM_BITS + 1) / 2 + 2;

	// Running square of the divisor: may pass the number by a little
	localparam int unsigned SQ_BITS = NUM_BITS + 2;

	// Bit counter for the remainder loop
	localparam int unsigned CNT_BITS = $clog2(NUM_BITS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BOUND,
		ST_DIV,
		ST_STEP,
		ST_DONE
	} state_t;

endpackage

// ----- hw/rtl/trial_division_prime_test_unit.sv -----
`timescale 1ns / 1ps

// Trial-division prime test. One number goes in, one is_prime flag comes out.
// Divisors 2, 3, 5, 7, 9, ... are tried while divisor squared is at most the
// number; each trial runs a restoring remainder one quotient bit per cycle, and
// a trial is NUM_BITS (31) remainder steps, one bound check and one divisor
// update. Numbers 0 and 1 skip the trial loop and go straight to the result.
// The block takes one number at a time (in_ready high only when idle), but a
// finished result sits in the output register so the next number can start
// while it waits to be taken.
module trial_division_prime_test_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [tdpt_pkg::NUM_BITS-1:0] number,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         is_prime
);

	import tdpt_pkg::*;

	state_t                state_q, state_d;

	logic [NUM_BITS-1:0]   n_q;
	logic [NUM_BITS-1:0]   n_sh_q;
	logic [DIV_BITS-1:0]   rem_q;
	logic [DIV_BITS-1:0]   d_q;
	logic [SQ_BITS-1:0]    sq_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  pend_q;
	logic                  is_prime_q;
	logic                  out_valid_q;

	// Control decode
	logic                  in_beat;
	logic                  out_beat;
	logic                  trivial;
	logic                  past_bound;
	logic                  div_last;
	logic                  rem_zero;
	logic                  publish;

	// Remainder step
	logic [DIV_BITS:0]     trial;
	logic                  trial_ge;
	logic [DIV_BITS-1:0]   rem_next;

	// Divisor / square update
	logic [DIV_BITS-1:0]   d_next;
	logic [SQ_BITS-1:0]    sq_next;

	// Remainder step: bring down next bit, subtract divisor if it fits
	always_comb begin
		trial    = {rem_q, n_sh_q[NUM_BITS-1]};
		trial_ge = (trial >= {1'b0, d_q});
		if (trial_ge) begin
			rem_next = DIV_BITS'(trial - {1'b0, d_q});
		end else begin
			rem_next = trial[DIV_BITS-1:0];
		end
	end

	// Next divisor: 2 -> 3, then odd steps; square kept incrementally
	always_comb begin
		if (d_q == DIV_BITS'(2)) begin
			d_next  = DIV_BITS'(3);
			sq_next = sq_q + SQ_BITS'(5);
		end else begin
			d_next  = d_q + DIV_BITS'(2);
			sq_next = sq_q + (SQ_BITS'(d_q) << 2) + SQ_BITS'(4);
		end
	end

	// Status terms for the sequencer
	always_comb begin
		trivial    = (number < NUM_BITS'(2));
		past_bound = ({2'b00, n_q} < sq_q);
		div_last   = (cnt_q == CNT_BITS'(1));
		rem_zero   = (rem_q == '0);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = trivial ? ST_DONE : ST_BOUND;
				end
			end
			ST_BOUND: begin
				state_d = past_bound ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				if (div_last) begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				state_d = rem_zero ? ST_DONE : ST_BOUND;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Handshake outputs
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		out_valid = out_valid_q;
		is_prime  = is_prime_q;
		in_beat   = in_valid && in_ready;
		out_beat  = out_valid_q && out_ready;
		publish   = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (publish) begin
				out_valid_q <= 1'b1;
			end else if (out_beat) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (in_beat) begin
			n_q    <= number;
			d_q    <= DIV_BITS'(2);
			sq_q   <= SQ_BITS'(4);
			pend_q <= 1'b0;
		end
		if (state_q == ST_BOUND) begin
			if (past_bound) begin
				pend_q <= 1'b1;
			end else begin
				n_sh_q <= n_q;
				rem_q  <= '0;
				cnt_q  <= CNT_BITS'(NUM_BITS);
			end
		end
		if (state_q == ST_DIV) begin
			rem_q  <= rem_next;
			n_sh_q <= n_sh_q << 1;
			cnt_q  <= cnt_q - CNT_BITS'(1);
		end
		if ((state_q == ST_STEP) && !rem_zero) begin
			d_q  <= d_next;
			sq_q <= sq_next;
		end
		if (publish) begin
			is_prime_q <= pend_q;
		end
	end

	// Remainder stays below the divisor throughout the loop
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_STEP) |-> (rem_q < d_q))
		else $error("remainder not below divisor");

	// Running square tracks the divisor
	a_square_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BOUND) |-> (sq_q == SQ_BITS'(d_q) * SQ_BITS'(d_q)))
		else $error("divisor square out of step");

	// A divisor that reaches the trial loop is at least two
	a_div_min: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (d_q >= DIV_BITS'(2)))
		else $error("trial divisor below two");

	// An accepted number always leaves idle
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> (state_q != ST_IDLE))
		else $error("sequencer idle after accepting a number");

endmodule
